// ----- rtl/sbs_pkg.sv -----
// shared constants, register codes and remainder-unit request/status types
// for the sample background subtractor; no dependencies
`timescale 1ns / 1ps

package sbs_pkg;

  localparam int DEF_IMAGE_WIDTH  = 320;
  localparam int DEF_IMAGE_HEIGHT = 240;
  localparam int DEF_NUM_SAMPLES  = 20;

  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

  localparam int DVD_W = 32;
  localparam int DSR_W = 9;

  // register reset values
  localparam logic [7:0] RST_MATCH_RADIUS  = 8'd20;
  localparam logic [4:0] RST_MIN_MATCHES   = 5'd2;
  localparam logic [8:0] RST_UPDATE_FACTOR = 9'd16;
  localparam logic [4:0] RST_SAMPLE_COUNT  = 5'd20;
  localparam logic [7:0] RST_BG_VALUE      = 8'd0;
  localparam logic [7:0] RST_FG_VALUE      = 8'd255;

  typedef enum logic [2:0] {
    REG_MATCH_RADIUS  = 3'd0,
    REG_MIN_MATCHES   = 3'd1,
    REG_UPDATE_FACTOR = 3'd2,
    REG_SAMPLE_COUNT  = 3'd3,
    REG_BG_VALUE      = 3'd4,
    REG_FG_VALUE      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DSR_W-1:0] rem;
  } div_stat_t;

endpackage

// ----- rtl/sbs_ram.sv -----
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`timescale 1ns / 1ps

module sbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sbs_mod.sv -----
// bit-serial remainder unit: 32-bit dividend modulo a 9-bit nonzero divisor,
// one quotient bit per cycle; uses sbs_pkg request/status types
`timescale 1ns / 1ps

module sbs_mod (
  input  logic               clk,
  input  logic               rst,
  input  sbs_pkg::div_req_t  req,
  output sbs_pkg::div_stat_t stat
);
  import sbs_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DSR_W-1:0] dsr;
  logic [DSR_W-1:0] rem;
  logic [DSR_W:0]   trial;
  logic [DSR_W-1:0] rem_next;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = DSR_W'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[DSR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[DVD_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.rem  = rem;

endmodule

// ----- rtl/sample_background_subtractor.sv -----
// Per-pixel sample background subtractor. Each pixel owns NUM_SAMPLES gray
// samples in one external-style sample RAM (one write and one registered read
// port). An init request sets up the address in three steps (row product,
// column add, sample base), writes every slot and hands off its result. A
// classify request sets up the address in the same way, then reads and checks
// each sample in turn (the registered RAM read needs the separate read step)
// until min_matches hits are found or the slots in use run out; a miss gives a
// foreground result. A background result adds random updates: every draw
// reduced modulo update_factor or the slot count goes through the shared
// bit-serial remainder unit, up to four such draws plus two neighbor offset
// draws, then the three address steps again for the neighbor and its write.
// The sequencer is idle again as the result appears; a finished result waits
// in the output register and does not hold off the next request.
// The sample RAM has no reset; reading a pixel never initialized gives
// undefined values.
// depends on sbs_pkg, sbs_ram, sbs_mod
`timescale 1ns / 1ps

module sample_background_subtractor #(
  parameter int IMAGE_WIDTH  = sbs_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = sbs_pkg::DEF_IMAGE_HEIGHT,
  parameter int NUM_SAMPLES  = sbs_pkg::DEF_NUM_SAMPLES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  logic [8:0] col,
  input  logic [7:0] row,
  input  logic [7:0] pixel_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] mask_value,
  output logic       is_background
);
  import sbs_pkg::*;

  localparam int COL_W  = $clog2(IMAGE_WIDTH);
  localparam int ROW_W  = $clog2(IMAGE_HEIGHT);
  localparam int SLOT_W = $clog2(NUM_SAMPLES + 1);
  localparam int DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT * NUM_SAMPLES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [COL_W:0] W_LIM = (COL_W + 1)'(IMAGE_WIDTH);
  localparam logic [ROW_W:0] H_LIM = (ROW_W + 1)'(IMAGE_HEIGHT);

  typedef enum logic [4:0] {
    IDLE, A_ROW, A_COL, A_SMP, INIT_WR, CMP_RD, CMP_CHK,
    U1_DRAW, U1_WAIT, S1_DRAW, S1_WAIT, U2_DRAW, U2_WAIT,
    GX_DRAW, GY_DRAW, S2_DRAW, S2_WAIT, NB_WR, DONE
  } state_t;

  state_t state;

  // configuration
  logic [7:0] match_radius;
  logic [4:0] min_matches;
  logic [8:0] update_factor;
  logic [4:0] sample_count;
  logic [7:0] bg_value;
  logic [7:0] fg_value;

  // request context
  logic              cmd;
  logic [COL_W-1:0]  cc;
  logic [ROW_W-1:0]  cr;
  logic [COL_W-1:0]  ac;
  logic [ROW_W-1:0]  ar;
  logic [7:0]        gray;
  logic              nb_phase;
  logic              res_bg;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] cnt_m;
  logic [SLOT_W-1:0] slot;
  logic [2:0]        gx;
  logic [ADDR_W-1:0] prod;
  logic [ADDR_W-1:0] pix;
  logic [ADDR_W-1:0] base;
  logic [31:0]       lfsr;
  logic [31:0]       lfsr_next;

  logic [31:0]       col_w;
  logic [31:0]       row_w;
  logic [31:0]       col_cl;
  logic [31:0]       row_cl;
  logic [7:0]        n8;
  logic [SLOT_W-1:0] n_eff;
  logic [8:0]        factor;
  logic [COL_W-1:0]  nb_c;
  logic [ROW_W-1:0]  nb_r;
  logic [2:0]        gy;
  logic [7:0]        diff;
  logic              hit;

  div_req_t          div_req;
  div_stat_t         div_stat;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  assign in_stall = (state != IDLE);

  // clamp position to the image
  always_comb begin
    col_w  = {23'd0, col};
    row_w  = {24'd0, row};
    col_cl = (col_w >= 32'(IMAGE_WIDTH))  ? 32'(IMAGE_WIDTH - 1)  : col_w;
    row_cl = (row_w >= 32'(IMAGE_HEIGHT)) ? 32'(IMAGE_HEIGHT - 1) : row_w;
  end

  always_comb begin
    if (sample_count == 5'd0) begin
      n8 = 8'd1;
    end else if (8'(sample_count) > 8'(NUM_SAMPLES)) begin
      n8 = 8'(NUM_SAMPLES);
    end else begin
      n8 = 8'(sample_count);
    end
    n_eff  = n8[SLOT_W-1:0];
    factor = (update_factor == 9'd0) ? 9'd1 : update_factor;
  end

  assign lfsr_next = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
  assign gy        = lfsr_next[2:0];

  // border-clamped neighbor position
  always_comb begin
    nb_c = cc;
    nb_r = cr;
    if (gx == 3'd0 || gx == 3'd6 || gx == 3'd7) begin
      if (cc != '0) nb_c = cc - 1'b1;
    end else if (gx >= 3'd2 && gx <= 3'd4) begin
      if ({1'b0, cc} + 1'b1 < W_LIM) nb_c = cc + 1'b1;
    end
    if (gy <= 3'd2) begin
      if (cr != '0) nb_r = cr - 1'b1;
    end else if (gy >= 3'd4 && gy <= 3'd6) begin
      if ({1'b0, cr} + 1'b1 < H_LIM) nb_r = cr + 1'b1;
    end
  end

  always_comb begin
    diff = (ram_rdata > gray) ? (ram_rdata - gray) : (gray - ram_rdata);
    hit  = (diff < match_radius);
  end

  always_comb begin
    div_req.start    = (state == U1_DRAW) || (state == S1_DRAW) ||
                       (state == U2_DRAW) || (state == S2_DRAW);
    div_req.dividend = lfsr_next;
    div_req.divisor  = ((state == S1_DRAW) || (state == S2_DRAW)) ?
                       9'(n_eff) : factor;
  end

  always_comb begin
    ram_we    = (state == INIT_WR) || (state == NB_WR) ||
                ((state == S1_WAIT) && div_stat.done);
    ram_raddr = base + ADDR_W'(idx);
    case (state)
      INIT_WR: ram_waddr = base + ADDR_W'(idx);
      S1_WAIT: ram_waddr = base + ADDR_W'(div_stat.rem[SLOT_W-1:0]);
      default: ram_waddr = base + ADDR_W'(slot);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      out_valid     <= 1'b0;
      lfsr          <= LFSR_SEED;
      match_radius  <= RST_MATCH_RADIUS;
      min_matches   <= RST_MIN_MATCHES;
      update_factor <= RST_UPDATE_FACTOR;
      sample_count  <= RST_SAMPLE_COUNT;
      bg_value      <= RST_BG_VALUE;
      fg_value      <= RST_FG_VALUE;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MATCH_RADIUS:  match_radius  <= cfg_data[7:0];
          REG_MIN_MATCHES:   min_matches   <= cfg_data[4:0];
          REG_UPDATE_FACTOR: update_factor <= cfg_data;
          REG_SAMPLE_COUNT:  sample_count  <= cfg_data[4:0];
          REG_BG_VALUE:      bg_value      <= cfg_data[7:0];
          REG_FG_VALUE:      fg_value      <= cfg_data[7:0];
          default: ;
        endcase
      end

      // the hand-off state loads the output register itself
      if (out_valid && !out_stall && state != DONE) out_valid <= 1'b0;

      case (state)
        IDLE: begin
          if (in_valid) begin
            cmd      <= command;
            cc       <= col_cl[COL_W-1:0];
            cr       <= row_cl[ROW_W-1:0];
            ac       <= col_cl[COL_W-1:0];
            ar       <= row_cl[ROW_W-1:0];
            gray     <= pixel_value;
            idx      <= '0;
            cnt_m    <= '0;
            nb_phase <= 1'b0;
            state    <= A_ROW;
          end
        end
        A_ROW: begin
          prod  <= ADDR_W'(ar * IMAGE_WIDTH);
          state <= A_COL;
        end
        A_COL: begin
          pix   <= prod + ADDR_W'(ac);
          state <= A_SMP;
        end
        A_SMP: begin
          base <= ADDR_W'(pix * NUM_SAMPLES);
          if (nb_phase)  state <= NB_WR;
          else if (!cmd) state <= INIT_WR;
          else           state <= CMP_RD;
        end
        INIT_WR: begin
          idx <= idx + 1'b1;
          if (idx == SLOT_W'(NUM_SAMPLES - 1)) begin
            res_bg <= 1'b1;
            state  <= DONE;
          end
        end
        CMP_RD: begin
          if (8'(cnt_m) >= 8'(min_matches)) begin
            res_bg <= 1'b1;
            state  <= U1_DRAW;
          end else if (idx >= n_eff) begin
            res_bg <= 1'b0;
            state  <= DONE;
          end else begin
            state <= CMP_CHK;
          end
        end
        CMP_CHK: begin
          if (hit) cnt_m <= cnt_m + 1'b1;
          idx   <= idx + 1'b1;
          state <= CMP_RD;
        end
        U1_DRAW: begin
          lfsr  <= lfsr_next;
          state <= U1_WAIT;
        end
        U1_WAIT: begin
          if (div_stat.done) begin
            state <= (div_stat.rem == '0) ? S1_DRAW : U2_DRAW;
          end
        end
        S1_DRAW: begin
          lfsr  <= lfsr_next;
          state <= S1_WAIT;
        end
        S1_WAIT: begin
          // own slot write happens here, see ram_we
          if (div_stat.done) state <= U2_DRAW;
        end
        U2_DRAW: begin
          lfsr  <= lfsr_next;
          state <= U2_WAIT;
        end
        U2_WAIT: begin
          if (div_stat.done) begin
            state <= (div_stat.rem == '0) ? GX_DRAW : DONE;
          end
        end
        GX_DRAW: begin
          lfsr  <= lfsr_next;
          gx    <= lfsr_next[2:0];
          state <= GY_DRAW;
        end
        GY_DRAW: begin
          lfsr  <= lfsr_next;
          ac    <= nb_c;
          ar    <= nb_r;
          state <= S2_DRAW;
        end
        S2_DRAW: begin
          lfsr  <= lfsr_next;
          state <= S2_WAIT;
        end
        S2_WAIT: begin
          if (div_stat.done) begin
            slot     <= div_stat.rem[SLOT_W-1:0];
            nb_phase <= 1'b1;
            state    <= A_ROW;
          end
        end
        NB_WR: begin
          state <= DONE;
        end
        DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            mask_value    <= res_bg ? bg_value : fg_value;
            is_background <= res_bg;
            state         <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  sbs_mod u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_stat)
  );

  sbs_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_samples (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (gray),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a new result only comes from the hand-off state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == DONE)
    else $error("result presented outside the hand-off state");

  // the remainder unit is never restarted while it is still iterating
  a_div_no_overlap: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_stat.busy)
    else $error("remainder unit started while busy");

  // compares stay within the slots in use
  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    state == CMP_CHK |-> idx < n_eff)
    else $error("compare index beyond slots in use");

  // a sample write never lands while a compare read is pending
  a_no_write_in_compare: assert property (@(posedge clk) disable iff (rst)
    state == CMP_CHK |-> !ram_we)
    else $error("sample write during compare");

endmodule

// ----- tb/tb_sample_background_subtractor.sv -----
`timescale 1ns / 1ps
// self-checking bench for sample_background_subtractor: a scoreboard class predicts the
// mask of every request along with its own copy of the sample store and the lfsr
// depends on sbs_pkg and the sample_background_subtractor rtl

module tb_sample_background_subtractor;
  import sbs_pkg::*;

  localparam int IMG_W = DEF_IMAGE_WIDTH;
  localparam int IMG_H = DEF_IMAGE_HEIGHT;
  localparam int SLOTS = DEF_NUM_SAMPLES;
  localparam int PIXELS = IMG_W * IMG_H;
  localparam int CLK_HALF = 4;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int SETTLE_CYCLES = 200;
  localparam bit CMD_INIT = 1'b0;
  localparam bit CMD_CLASSIFY = 1'b1;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    bit [7:0] mask;
    bit       bg;
  } mask_result_t;

  class mask_scoreboard;
    bit [7:0]     samples [];
    bit [31:0]    lfsr;
    bit [7:0]     radius;
    bit [4:0]     min_hits;
    bit [8:0]     factor;
    bit [4:0]     count;
    bit [7:0]     bg_val;
    bit [7:0]     fg_val;
    mask_result_t expected_masks [$];
    int           mismatches;

    function new();
      samples = new[PIXELS * SLOTS];
      lfsr = LFSR_SEED;
      radius = RST_MATCH_RADIUS;
      min_hits = RST_MIN_MATCHES;
      factor = RST_UPDATE_FACTOR;
      count = RST_SAMPLE_COUNT;
      bg_val = RST_BG_VALUE;
      fg_val = RST_FG_VALUE;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, bit [8:0] v);
      case (idx)
        REG_MATCH_RADIUS:  radius = v[7:0];
        REG_MIN_MATCHES:   min_hits = v[4:0];
        REG_UPDATE_FACTOR: factor = v;
        REG_SAMPLE_COUNT:  count = v[4:0];
        REG_BG_VALUE:      bg_val = v[7:0];
        REG_FG_VALUE:      fg_val = v[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned pixel_base(int unsigned c, int unsigned r);
      if (c >= IMG_W) c = IMG_W - 1;
      if (r >= IMG_H) r = IMG_H - 1;
      return (r * IMG_W + c) * SLOTS;
    endfunction

    function bit [7:0] peek(int unsigned c, int unsigned r, int unsigned slot);
      return samples[pixel_base(c, r) + slot];
    endfunction

    function int unsigned next_draw();
      lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
      return lfsr;
    endfunction

    function int pending();
      return expected_masks.size();
    endfunction

    function void note_request(bit cmd, bit [8:0] c_in, bit [7:0] r_in, bit [7:0] gray);
      int unsigned c, r, base, n, f, hits, idx, s, diff, gx, gy, nc, nr, i;
      mask_result_t res;
      c = (c_in >= IMG_W) ? IMG_W - 1 : c_in;
      r = (r_in >= IMG_H) ? IMG_H - 1 : r_in;
      base = pixel_base(c, r);
      res.mask = bg_val;
      res.bg = 1'b1;
      if (cmd == CMD_INIT) begin
        for (i = 0; i < SLOTS; i++) samples[base + i] = gray;
      end else begin
        n = (count == 0) ? 1 : (count > SLOTS) ? SLOTS : count;
        f = (factor == 0) ? 1 : factor;
        hits = 0;
        idx = 0;
        while (hits < min_hits && idx < n) begin
          s = samples[base + idx];
          diff = (s > gray) ? s - gray : gray - s;
          if (diff < radius) hits++;
          idx++;
        end
        if (hits < min_hits) begin
          res.mask = fg_val;
          res.bg = 1'b0;
        end else begin
          // own-slot refresh, then an independent refresh of a clamped neighbor
          if (next_draw() % f == 0) samples[base + next_draw() % n] = gray;
          if (next_draw() % f == 0) begin
            gx = next_draw() & 7;
            gy = next_draw() & 7;
            nc = c;
            nr = r;
            if (gx == 0 || gx >= 6) begin
              if (nc > 0) nc--;
            end else if (gx >= 2 && gx <= 4) begin
              if (nc + 1 < IMG_W) nc++;
            end
            if (gy <= 2) begin
              if (nr > 0) nr--;
            end else if (gy >= 4 && gy <= 6) begin
              if (nr + 1 < IMG_H) nr++;
            end
            samples[pixel_base(nc, nr) + next_draw() % n] = gray;
          end
        end
      end
      expected_masks.push_back(res);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function void check_mask(logic [7:0] mask, logic isbg);
      mask_result_t want;
      if (expected_masks.size() == 0) begin
        flag($sformatf("result with no request pending: mask %0d bg %0b", mask, isbg));
      end else begin
        want = expected_masks.pop_front();
        if (mask !== want.mask || isbg !== want.bg)
          flag($sformatf("mask %0d bg %0b, expected mask %0d bg %0b",
                         mask, isbg, want.mask, want.bg));
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [8:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic       command;
  logic [8:0] col;
  logic [7:0] row;
  logic [7:0] pixel_value;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] mask_value;
  logic       is_background;

  mask_scoreboard sb = new();
  bit [16:0]      pool [$];
  int             send_pct;
  int             recv_pct;
  int unsigned    cycle_count;

  sample_background_subtractor uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .col(col),
    .row(row),
    .pixel_value(pixel_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .mask_value(mask_value),
    .is_background(is_background)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_mask(mask_value, is_background);
    out_stall <= !rst && ($urandom_range(0, 99) < recv_pct);
  end

  // in_valid is left high after acceptance so back-to-back requests need one assignment
  task automatic send_request(bit cmd, bit [8:0] c, bit [7:0] r, bit [7:0] g);
    if ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_pct);
    end
    in_valid <= 1'b1;
    command <= cmd;
    col <= c;
    row <= r;
    pixel_value <= g;
    do @(posedge clk); while (in_stall);
    sb.note_request(cmd, c, r, g);
  endtask

  task automatic init_pixel(bit [8:0] c, bit [7:0] r, bit [7:0] g);
    pool.push_back({c, r});
    send_request(CMD_INIT, c, r, g);
  endtask

  task automatic random_request();
    bit [8:0] c;
    bit [7:0] r;
    int       near;
    if (pool.size() == 0 || $urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 3))
        0: begin
          c = 9'($urandom_range(0, 5));
          r = 8'($urandom_range(0, 5));
        end
        1: begin
          c = 9'($urandom_range(314, 319));
          r = 8'($urandom_range(234, 239));
        end
        2: begin
          c = 9'($urandom_range(0, 511));
          r = 8'($urandom_range(0, 255));
        end
        default: begin
          c = 9'($urandom_range(312, 511));
          r = 8'($urandom_range(232, 255));
        end
      endcase
      init_pixel(c, r, 8'($urandom_range(0, 255)));
    end else begin
      {c, r} = pool[$urandom_range(0, pool.size() - 1)];
      // mostly gray values near a stored sample so that matches happen
      if ($urandom_range(0, 99) < 20) begin
        near = $urandom_range(0, 255);
      end else begin
        near = int'(sb.peek(c, r, $urandom_range(0, SLOTS - 1))) +
               int'($urandom_range(0, 60)) - 30;
        if (near < 0) near = 0;
        if (near > 255) near = 255;
      end
      send_request(CMD_CLASSIFY, c, r, near[7:0]);
    end
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, bit [8:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic run_phase(bit [8:0] rad, bit [8:0] minm, bit [8:0] fac, bit [8:0] cnt,
                           bit [8:0] bgv, bit [8:0] fgv, idle_mode_t mode, int items,
                           bit hold_mid);
    int i;
    write_reg(REG_MATCH_RADIUS, rad);
    write_reg(REG_MIN_MATCHES, minm);
    write_reg(REG_UPDATE_FACTOR, fac);
    write_reg(REG_SAMPLE_COUNT, cnt);
    write_reg(REG_BG_VALUE, bgv);
    write_reg(REG_FG_VALUE, fgv);
    cfg_we <= 1'b0;
    send_pct = (mode == IDLE_SENDER) ? 74 : (mode == IDLE_BOTH) ? 18 : 0;
    recv_pct = (mode == IDLE_RECEIVER) ? 74 : (mode == IDLE_BOTH) ? 18 : 0;
    for (i = 0; i < items; i++) begin
      if (hold_mid && i == items / 2) drain_requests();
      random_request();
    end
    drain_requests();
  endtask

  initial begin
    int i;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_MATCH_RADIUS;
    cfg_data = '0;
    in_valid = 1'b0;
    command = CMD_INIT;
    col = '0;
    row = '0;
    pixel_value = '0;
    out_stall = 1'b0;
    cycle_count = 0;
    send_pct = 0;
    recv_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: corners, out-of-image saturation, radius boundary
    init_pixel(9'd0, 8'd0, 8'd0);
    init_pixel(9'd319, 8'd239, 8'd255);
    init_pixel(9'd511, 8'd255, 8'd128);
    init_pixel(9'd320, 8'd5, 8'd200);
    init_pixel(9'd1, 8'd0, 8'd10);
    init_pixel(9'd0, 8'd1, 8'd255);
    send_request(CMD_CLASSIFY, 9'd0, 8'd0, 8'd0);
    send_request(CMD_CLASSIFY, 9'd0, 8'd0, 8'd255);
    send_request(CMD_CLASSIFY, 9'd319, 8'd239, 8'd128);
    send_request(CMD_CLASSIFY, 9'd511, 8'd255, 8'd147);
    send_request(CMD_CLASSIFY, 9'd319, 8'd239, 8'd148);
    send_request(CMD_CLASSIFY, 9'd320, 8'd5, 8'd200);
    send_request(CMD_CLASSIFY, 9'd319, 8'd5, 8'd0);
    send_request(CMD_CLASSIFY, 9'd1, 8'd0, 8'd29);
    send_request(CMD_CLASSIFY, 9'd0, 8'd1, 8'd235);
    for (i = 0; i < 8; i++) send_request(CMD_CLASSIFY, 9'd0, 8'd0, 8'd3);
    drain_requests();

    run_phase(9'd20, 9'd2, 9'd16, 9'd20, 9'd0, 9'd255, IDLE_NONE, 120, 1'b1);
    run_phase(9'd255, 9'd20, 9'd1, 9'd20, 9'd255, 9'd0, IDLE_SENDER, 110, 1'b0);
    run_phase(9'd0, 9'd1, 9'd256, 9'd1, 9'd85, 9'd170, IDLE_RECEIVER, 100, 1'b0);
    // zero min matches, factor and count take their degenerate meanings
    run_phase(9'd30, 9'd0, 9'd0, 9'd0, 9'd1, 9'd254, IDLE_BOTH, 110, 1'b0);
    run_phase(9'd40, 9'd31, 9'd511, 9'd31, 9'd7, 9'd200, IDLE_NONE, 80, 1'b0);
    run_phase(9'($urandom_range(10, 60)), 9'($urandom_range(1, 4)),
              9'($urandom_range(1, 8)), 9'($urandom_range(1, 20)),
              9'($urandom_range(0, 255)), 9'($urandom_range(0, 255)),
              IDLE_SENDER, 120, 1'b0);
    run_phase(9'd25, 9'd3, 9'd2, 9'd5, 9'd0, 9'd255, IDLE_RECEIVER, 120, 1'b0);
    run_phase(9'($urandom_range(0, 255)), 9'($urandom_range(0, 31)),
              9'($urandom_range(0, 511)), 9'($urandom_range(0, 31)),
              9'($urandom_range(0, 255)), 9'($urandom_range(0, 255)),
              IDLE_BOTH, 120, 1'b0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sbs_pkg.sv
rtl/sbs_ram.sv
rtl/sbs_mod.sv
rtl/sample_background_subtractor.sv
tb/tb_sample_background_subtractor.sv
